FILE: rtl/core/otr_pkg.sv
`timescale 1ns / 1ps

package otr_pkg;

    localparam int DEFAULT_RING_DEPTH = 64;

    // drop counter sticks here
    localparam logic [15:0] LOSS_SAT = 16'hFFFF;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_RECORD  = 2'd0;
    localparam logic [1:0] REQ_PEEK    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    localparam int PENDING_W = 7;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] tick;
        logic [7:0]  flags;
        logic [7:0]  stage;
    } entry_t;

    typedef struct packed {
        logic                 found;
        logic [PENDING_W-1:0] pending;
        logic [15:0]          dropped;
    } status_t;

endpackage

FILE: rtl/core/overwrite_oldest_trace_ring.sv
`timescale 1ns / 1ps

// Trace ring that overwrites its oldest entry when full and counts losses.
// Requests arrive on the s_ stream, kind on s_tuser: record, peek, advance,
// or no operation for the spare code. Every request gives exactly one
// result transfer on the m_ stream carrying the peeked entry (zero unless
// found), the pending count clamped to the ring depth and the drop count.
// The request is taken at one edge, where the cursors update and the entry
// memory is read, and the result is valid in the cycle after. Throughput is
// one request per cycle while m_tready is high; the single-port-per-direction
// entry memory and the cursor update both complete within the accepting cycle.
// When m_tready is low the result register holds and s_tready falls, so at
// most one result is buffered. A record followed by a peek of the same slot
// sees the new entry since the write lands on the accepting edge.
// Reset (aresetn low, synchronous) clears both cursors, the drop counter and
// the output valid; entry contents are not cleared and are only returned after
// being written.
module overwrite_oldest_trace_ring #(
    parameter int RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // stage[7:0], flags[15:8], tick[31:16], value[63:32], index[79:64],
    // advance_by[95:80]
    input  logic [95:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_stage[7:0], out_flags[15:8], out_tick[31:16], out_value[63:32],
    // pending[70:64], dropped[86:71], zero[87]
    output logic [87:0] m_tdata,
    // found[0]
    output logic [0:0]  m_tuser
);

    localparam int AW = $clog2(RING_DEPTH);

    logic             accept;
    logic             out_valid_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    otr_pkg::entry_t  rec_entry;
    otr_pkg::entry_t  rd_data;
    otr_pkg::entry_t  out_entry;
    otr_pkg::status_t status;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    assign rec_entry.stage = s_tdata[7:0];
    assign rec_entry.flags = s_tdata[15:8];
    assign rec_entry.tick  = s_tdata[31:16];
    assign rec_entry.value = s_tdata[63:32];

    otr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req_type   (s_tuser),
        .index      (s_tdata[79:64]),
        .advance_by (s_tdata[95:80]),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .status     (status)
    );

    otr_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rec_entry),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry fields read as zero unless the peek hit
    assign out_entry = status.found ? rd_data : '0;

    assign m_tvalid       = out_valid_reg;
    assign m_tuser        = status.found;
    assign m_tdata[7:0]   = out_entry.stage;
    assign m_tdata[15:8]  = out_entry.flags;
    assign m_tdata[31:16] = out_entry.tick;
    assign m_tdata[63:32] = out_entry.value;
    assign m_tdata[70:64] = status.pending;
    assign m_tdata[86:71] = status.dropped;
    assign m_tdata[87]    = 1'b0;

endmodule

FILE: rtl/core/otr_mem.sv
`timescale 1ns / 1ps

module otr_mem #(
    parameter int RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  otr_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output otr_pkg::entry_t     rd_data
);

    otr_pkg::entry_t mem [RING_DEPTH];
    otr_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held while the result waits downstream
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/otr_ctrl.sv
`timescale 1ns / 1ps

module otr_ctrl #(
    parameter int RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        req_type,
    input  logic [15:0]       index,
    input  logic [15:0]       advance_by,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [AW-1:0]     rd_addr,
    output otr_pkg::status_t  status
);

    localparam logic [15:0] DEPTH16 = 16'(RING_DEPTH);

    logic [15:0] wp_reg, wp_next;
    logic [15:0] fp_reg, fp_next;
    logic [15:0] loss_reg, loss_next;
    otr_pkg::status_t status_reg, status_next;

    logic [15:0] raw_pend;
    logic [15:0] wp_inc;
    logic [15:0] rec_pend;
    logic [15:0] adv_cnt;
    logic [15:0] peek_cur;
    logic [15:0] new_pend;
    logic [15:0] clamp_pend;
    logic        hit;

    always_comb begin
        raw_pend = wp_reg - fp_reg;
        wp_inc   = wp_reg + 16'd1;
        rec_pend = wp_inc - fp_reg;
        adv_cnt  = (advance_by > raw_pend) ? raw_pend : advance_by;
        peek_cur = fp_reg + index;

        wp_next   = wp_reg;
        fp_next   = fp_reg;
        loss_next = loss_reg;
        hit       = 1'b0;

        case (req_type)
            otr_pkg::REQ_RECORD: begin
                wp_next = wp_inc;
                // ring overfull: lose only the oldest entry
                if (rec_pend > DEPTH16) begin
                    fp_next = wp_inc - DEPTH16;
                    if (loss_reg != otr_pkg::LOSS_SAT) begin
                        loss_next = loss_reg + 16'd1;
                    end
                end
            end
            otr_pkg::REQ_PEEK: begin
                hit = (index < raw_pend);
            end
            otr_pkg::REQ_ADVANCE: begin
                fp_next = fp_reg + adv_cnt;
            end
            default: begin
            end
        endcase

        new_pend   = wp_next - fp_next;
        clamp_pend = (new_pend > DEPTH16) ? DEPTH16 : new_pend;

        status_next.found   = hit;
        status_next.pending = clamp_pend[otr_pkg::PENDING_W-1:0];
        status_next.dropped = loss_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fp_reg   <= '0;
            loss_reg <= '0;
        end else if (accept) begin
            wp_reg   <= wp_next;
            fp_reg   <= fp_next;
            loss_reg <= loss_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    assign wr_en   = accept && (req_type == otr_pkg::REQ_RECORD);
    assign wr_addr = wp_reg[AW-1:0];
    assign rd_addr = peek_cur[AW-1:0];
    assign status  = status_reg;

endmodule

FILE: tb/overwrite_oldest_trace_ring_tb.sv
`timescale 1ns / 1ps

module overwrite_oldest_trace_ring_tb;

    localparam int DEPTH = otr_pkg::DEFAULT_RING_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam logic [15:0] DEPTH16 = 16'(DEPTH);
    localparam int IDLE_LIMIT = 2000;
    // spare request code: status only
    localparam logic [1:0] REQ_NOP = 2'd3;

    typedef struct {
        logic            found;
        otr_pkg::entry_t ent;
        logic [6:0]      pending;
        logic [15:0]     dropped;
    } ring_outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;

    // mirror of the ring, updated on every accepted request
    otr_pkg::entry_t mirror_mem [DEPTH];
    logic [15:0] mirror_wr = '0;
    logic [15:0] mirror_fl = '0;
    logic [15:0] mirror_lost = '0;

    ring_outcome_t outcome_q[$];

    bit stall_en = 1'b1;
    int fail_cnt = 0;
    int idle_cycles = 0;
    int n_record = 0, n_peek = 0, n_hit = 0, n_adv = 0, n_nop = 0;

    overwrite_oldest_trace_ring #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic ring_outcome_t ring_outcome(logic [1:0] kind, logic [95:0] data);
        ring_outcome_t r;
        logic [15:0] backlog, idx, cnt, slot, clamped;
        r.found = 1'b0;
        r.ent = '0;
        backlog = mirror_wr - mirror_fl;
        case (kind)
            otr_pkg::REQ_RECORD: begin
                mirror_mem[mirror_wr[AW-1:0]] = data[63:0];
                mirror_wr = mirror_wr + 16'd1;
                backlog = mirror_wr - mirror_fl;
                if (backlog > DEPTH16) begin
                    // full: lose only the oldest entry
                    mirror_fl = mirror_wr - DEPTH16;
                    if (mirror_lost != otr_pkg::LOSS_SAT)
                        mirror_lost = mirror_lost + 16'd1;
                end
            end
            otr_pkg::REQ_PEEK: begin
                idx = data[79:64];
                if (idx < backlog) begin
                    slot = mirror_fl + idx;
                    r.found = 1'b1;
                    r.ent = mirror_mem[slot[AW-1:0]];
                end
            end
            otr_pkg::REQ_ADVANCE: begin
                cnt = data[95:80];
                if (cnt > backlog)
                    cnt = backlog;
                mirror_fl = mirror_fl + cnt;
            end
            default: ;
        endcase
        backlog = mirror_wr - mirror_fl;
        clamped = (backlog > DEPTH16) ? DEPTH16 : backlog;
        r.pending = clamped[6:0];
        r.dropped = mirror_lost;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // results are checked before the request of the same edge is predicted
    always @(posedge aclk) begin
        ring_outcome_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    fail_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tuser[0] === 1'b1)
                        n_hit++;
                    check_field("found", 32'(want.found), 32'(m_tuser[0]));
                    check_field("out_stage", 32'(want.ent.stage), 32'(m_tdata[7:0]));
                    check_field("out_flags", 32'(want.ent.flags), 32'(m_tdata[15:8]));
                    check_field("out_tick", 32'(want.ent.tick), 32'(m_tdata[31:16]));
                    check_field("out_value", want.ent.value, m_tdata[63:32]);
                    check_field("pending", 32'(want.pending), 32'(m_tdata[70:64]));
                    check_field("dropped", 32'(want.dropped), 32'(m_tdata[86:71]));
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    otr_pkg::REQ_RECORD:  n_record++;
                    otr_pkg::REQ_PEEK:    n_peek++;
                    otr_pkg::REQ_ADVANCE: n_adv++;
                    default:              n_nop++;
                endcase
                outcome_q.push_back(ring_outcome(s_tuser, s_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, the odd long one
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [95:0] noise_word();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // returns at the accepting edge with s_tvalid still high
    task automatic push_req(input logic [1:0] kind, input logic [95:0] data);
        if (stall_en && $urandom_range(0, 1) == 1) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic record_rand();
        push_req(otr_pkg::REQ_RECORD, noise_word());
    endtask

    task automatic peek_at(input logic [15:0] idx);
        logic [95:0] d;
        d = noise_word();
        d[79:64] = idx;
        push_req(otr_pkg::REQ_PEEK, d);
    endtask

    task automatic advance_by(input logic [15:0] cnt);
        logic [95:0] d;
        d = noise_word();
        d[95:80] = cnt;
        push_req(otr_pkg::REQ_ADVANCE, d);
    endtask

    task automatic wait_all_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_and_extremes();
        peek_at(16'd0);
        advance_by(16'hFFFF);
        push_req(REQ_NOP, noise_word());
        push_req(otr_pkg::REQ_RECORD, '0);
        push_req(otr_pkg::REQ_RECORD, '1);
        push_req(otr_pkg::REQ_RECORD, {32'h0, 32'hA5A5_5A5A, 16'h1234, 8'h80, 8'h01});
        peek_at(16'd0);
        peek_at(16'd1);
        peek_at(16'd2);
        peek_at(16'd3);
        peek_at(16'hFFFF);
        advance_by(16'd0);
        advance_by(16'd1);
        peek_at(16'd0);
        peek_at(16'd2);
        advance_by(16'hFFFF);
        peek_at(16'd0);
        push_req(REQ_NOP, '1);
        // write then read back the same slot with the next request
        record_rand();
        peek_at(16'd0);
    endtask

    task automatic test_overwrite_oldest();
        repeat (DEPTH + 6) record_rand();
        for (int i = 0; i <= DEPTH; i++)
            peek_at(16'($urandom_range(0, DEPTH)));
        advance_by(16'd5);
        peek_at(16'd0);
        peek_at(16'(DEPTH - 6));
        repeat (8) record_rand();
        peek_at(16'(DEPTH - 1));
    endtask

    task automatic test_random_traffic(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0)
                stall_en = ($urandom_range(0, 3) != 0);
            if (i == count / 2)
                wait_all_done();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                record_rand();
            else if (pick < 75)
                peek_at(16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, DEPTH + 6)));
            else if (pick < 92)
                advance_by(16'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 8)));
            else
                push_req(REQ_NOP, noise_word());
        end
        stall_en = 1'b1;
    endtask

    // a long run of records, a peek after every sixteenth, that keeps the ring overfull, first unstalled
    task automatic test_sustained_overwrite();
        for (int i = 0; i < 200; i++) begin
            stall_en = (i >= 100);
            record_rand();
            if (i % 16 == 15)
                peek_at(16'($urandom_range(0, DEPTH + 4)));
        end
        stall_en = 1'b1;
        repeat (4) record_rand();
        peek_at(16'd0);
        peek_at(16'(DEPTH - 1));
        advance_by(16'd3);
        peek_at(16'd0);
        push_req(REQ_NOP, noise_word());
        advance_by(16'hFFFF);
        peek_at(16'd0);
        record_rand();
        peek_at(16'd0);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_NOP;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_extremes();
        test_overwrite_oldest();
        test_random_traffic(1000);
        test_sustained_overwrite();

        wait_all_done();
        repeat (8) @(posedge aclk);

        $display("Covered %0d records, %0d peeks (%0d found), %0d advances, %0d no-ops",
                 n_record, n_peek, n_hit, n_adv, n_nop);
        $display("Write cursor ended at %0d, drop count ended at %0d",
                 mirror_wr, mirror_lost);
        if (fail_cnt == 0 && outcome_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
